// ===== rtl/software_timer_table_core_macros.svh =====
// Assertion macros shared by the checker of the timer table.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef SOFTWARE_TIMER_TABLE_CORE_MACROS_SVH
`define SOFTWARE_TIMER_TABLE_CORE_MACROS_SVH
// Assert that a property holds on every rising clock edge outside reset.
`define STT_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`endif

// ===== rtl/stt_pkg.sv =====
// Package of the software timer table: table size, actions and event codes.
// Depends on nothing.
`timescale 1ns / 1ps
package stt_pkg;
	localparam int unsigned TimerSlots = 16;
	localparam int unsigned IdxW = $clog2(TimerSlots);

	typedef enum logic [2:0] {
		ACT_ADD = 3'd0,
		ACT_GET = 3'd1,
		ACT_START = 3'd2,
		ACT_STOP = 3'd3,
		ACT_DELETE = 3'd4,
		ACT_TICK = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		EV_DONE = 2'd0,
		EV_TIMEOUT = 2'd1,
		EV_REMOVED = 2'd2
	} event_kind_t;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] token;
		logic [7:0] run_count;
		logic [31:0] interval_ms;
		logic [31:0] current_time;
		logic [31:0] user_data;
		logic has_timeout_handler;
		logic has_delete_handler;
	} req_t;

	typedef struct packed {
		logic [1:0] event_kind;
		logic [7:0] event_token;
		logic [31:0] event_data;
		logic status;
		logic last;
	} rsp_t;

	typedef struct packed {
		logic used;
		logic [7:0] token;
		logic running;
		logic [7:0] remaining;
		logic [31:0] start_time;
		logic [31:0] period;
		logic [31:0] data;
		logic [1:0] flags;
	} slot_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_req;
		logic insert;
		logic remove;
		logic set_start;
		logic set_stop;
		logic tick_zero;
		logic tick_fire;
		logic [IdxW-1:0] idx;
	} cmd_t;

	// Status of the addressed slot and the request.
	typedef struct packed {
		logic in_range;
		logic used;
		logic match;
		logic full;
		logic wrap_skip;
		logic expired;
		logic last_count;
		logic [1:0] flags;
	} sts_t;
endpackage

// ===== rtl/stt_stream_if.sv =====
// Valid/ready channel interface carrying one payload type.
// Depends on nothing; the payload type is given per instance.
`timescale 1ns / 1ps
interface stt_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/stt_datapath.sv =====
// Slot table storage, request register, shift logic and per-slot status.
// Depends on stt_pkg.
`timescale 1ns / 1ps
module stt_datapath (
	input logic clk,
	input logic arst_n,
	input stt_pkg::req_t req,
	input stt_pkg::cmd_t cmd,
	output stt_pkg::sts_t sts,
	output stt_pkg::req_t req_q_o,
	output stt_pkg::slot_t slot_o
);
	localparam int unsigned N = stt_pkg::TimerSlots;
	stt_pkg::req_t req_q;
	stt_pkg::slot_t slot_q [N];
	logic [N-1:0] used_q;
	stt_pkg::slot_t cur;
	logic [31:0] due;

	assign req_q_o = req_q;
	always_comb begin
		cur = slot_q[cmd.idx];
		cur.used = used_q[cmd.idx];
	end
	assign slot_o = cur;
	assign due = cur.start_time + cur.period;

	always_comb begin
		sts.in_range = ({1'b0, cmd.idx} < (stt_pkg::IdxW + 1)'(N));
		sts.used = cur.used;
		sts.match = cur.used && (cur.token == req_q.token);
		sts.full = used_q[N-1];
		sts.wrap_skip = (32'hFFFF_FFFF - req_q.current_time) < cur.period;
		sts.expired = cur.running && (req_q.current_time >= due);
		sts.last_count = (cur.remaining == 8'd1);
		sts.flags = cur.flags;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cmd.insert) begin
			used_q <= {used_q[N-2:0], 1'b1};
		end else if (cmd.remove) begin
			for (int i = 0; i < N; i++) begin
				if (i >= int'(cmd.idx)) begin
					used_q[i] <= (i + 1 < N) ? used_q[(i + 1) % N] : 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= req;
		end
		if (cmd.insert) begin
			for (int i = N - 1; i > 0; i--) begin
				slot_q[i] <= slot_q[i - 1];
			end
			slot_q[0] <= '{used: 1'b1, token: req_q.token, running: 1'b0,
				remaining: req_q.run_count, start_time: 32'd0, period: 32'd0,
				data: req_q.user_data,
				flags: {req_q.has_delete_handler, req_q.has_timeout_handler}};
		end else if (cmd.remove) begin
			for (int i = 0; i < N - 1; i++) begin
				if (i >= int'(cmd.idx)) begin
					slot_q[i] <= slot_q[i + 1];
				end
			end
		end else if (cmd.set_start) begin
			slot_q[cmd.idx].running <= 1'b1;
			slot_q[cmd.idx].start_time <= req_q.current_time;
			slot_q[cmd.idx].period <= req_q.interval_ms;
		end else if (cmd.set_stop) begin
			slot_q[cmd.idx].running <= 1'b0;
		end else if (cmd.tick_zero) begin
			slot_q[cmd.idx].start_time <= 32'd0;
		end else if (cmd.tick_fire) begin
			slot_q[cmd.idx].start_time <= req_q.current_time;
			if (cur.remaining != 8'd0) begin
				slot_q[cmd.idx].remaining <= cur.remaining - 8'd1;
			end
		end
	end
endmodule

// ===== rtl/stt_controller.sv =====
// Controller: searches, scans and emits events and the done transaction.
// Depends on stt_pkg.
`timescale 1ns / 1ps
module stt_controller (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	output stt_pkg::rsp_t rsp,
	input stt_pkg::req_t req_q,
	input stt_pkg::slot_t slot,
	input stt_pkg::sts_t sts,
	output stt_pkg::cmd_t cmd
);
	typedef enum logic [2:0] {
		S_IDLE, S_SEARCH, S_TICK, S_EMIT, S_APPLY, S_DONE
	} state_t;

	state_t state_q;
	logic [stt_pkg::IdxW-1:0] idx_q;
	logic [stt_pkg::IdxW:0] cnt_q;
	logic found_q, status_q, del_ev_q, remove_q;
	logic [31:0] ddata_q;
	stt_pkg::rsp_t rsp_q;
	logic out_valid_q;
	localparam logic [stt_pkg::IdxW:0] Last = (stt_pkg::IdxW + 1)'(stt_pkg::TimerSlots - 1);

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign rsp = rsp_q;
	logic free;
	assign free = !out_valid_q || out_ready;

	always_comb begin
		cmd = '0;
		cmd.idx = idx_q;
		cmd.load_req = in_ready && in_valid;
		if (state_q == S_APPLY && free) begin
			unique case (req_q.action)
				stt_pkg::ACT_ADD: cmd.insert = !found_q && !sts.full;
				stt_pkg::ACT_START: cmd.set_start = found_q;
				stt_pkg::ACT_STOP: cmd.set_stop = found_q;
				stt_pkg::ACT_DELETE: cmd.remove = found_q;
				default: ;
			endcase
		end
		if (state_q == S_TICK && sts.used) begin
			if (sts.wrap_skip) begin
				cmd.tick_zero = 1'b1;
			end else if (sts.expired) begin
				cmd.tick_fire = 1'b1;
			end
		end
		if (state_q == S_EMIT && free && remove_q && !del_ev_q) begin
			cmd.remove = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			cnt_q <= '0;
			found_q <= 1'b0;
			status_q <= 1'b0;
			del_ev_q <= 1'b0;
			remove_q <= 1'b0;
			ddata_q <= '0;
			out_valid_q <= 1'b0;
			rsp_q <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						idx_q <= '0;
						cnt_q <= '0;
						found_q <= 1'b0;
						ddata_q <= '0;
						state_q <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (req_q.action == stt_pkg::ACT_TICK) begin
						state_q <= S_TICK;
					end else if (req_q.action > stt_pkg::ACT_TICK) begin
						status_q <= 1'b1;
						state_q <= S_DONE;
					end else if (sts.match) begin
						found_q <= 1'b1;
						ddata_q <= (req_q.action == stt_pkg::ACT_GET) ? slot.data : 32'd0;
						state_q <= S_APPLY;
					end else if (cnt_q == Last) begin
						state_q <= S_APPLY;
					end else begin
						idx_q <= idx_q + 1'b1;
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_APPLY: begin
					if (free) begin
						status_q <= !(found_q ||
							(req_q.action == stt_pkg::ACT_ADD && !sts.full));
						if (req_q.action == stt_pkg::ACT_DELETE && found_q &&
								sts.flags[1]) begin
							rsp_q <= '{event_kind: stt_pkg::EV_REMOVED,
								event_token: slot.token, event_data: slot.data,
								status: 1'b0, last: 1'b0};
							out_valid_q <= 1'b1;
						end
						state_q <= S_DONE;
					end
				end
				S_TICK: begin
					if (!sts.used || !sts.in_range) begin
						status_q <= 1'b0;
						state_q <= S_DONE;
					end else if (!sts.wrap_skip && sts.expired) begin
						del_ev_q <= sts.flags[0];
						remove_q <= sts.last_count;
						state_q <= S_EMIT;
					end else if (cnt_q == Last) begin
						status_q <= 1'b0;
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_EMIT: begin
					if (free) begin
						if (del_ev_q) begin
							rsp_q <= '{event_kind: stt_pkg::EV_TIMEOUT,
								event_token: slot.token, event_data: slot.data,
								status: 1'b0, last: 1'b0};
							out_valid_q <= 1'b1;
							del_ev_q <= 1'b0;
						end else if (remove_q) begin
							if (slot.flags[1]) begin
								rsp_q <= '{event_kind: stt_pkg::EV_REMOVED,
									event_token: slot.token, event_data: slot.data,
									status: 1'b0, last: 1'b0};
								out_valid_q <= 1'b1;
							end
							remove_q <= 1'b0;
							state_q <= S_TICK;
						end else if (cnt_q == Last) begin
							status_q <= 1'b0;
							state_q <= S_DONE;
						end else begin
							idx_q <= idx_q + 1'b1;
							cnt_q <= cnt_q + 1'b1;
							state_q <= S_TICK;
						end
					end
				end
				S_DONE: begin
					if (free) begin
						rsp_q <= '{event_kind: stt_pkg::EV_DONE, event_token: req_q.token,
							event_data: ddata_q, status: status_q, last: 1'b1};
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/software_timer_table_core.sv =====
// Top level of the software timer table: joins controller and datapath.
// Depends on stt_pkg, stt_stream_if, stt_controller and stt_datapath.
//
// Usage: requests arrive on req_ch, one action per transaction; results leave
// on rsp_ch. Each request yields zero or more timeout or removal events and
// then exactly one done transaction with last set.
// A lookup walks the table one slot per cycle; add, get, start, stop and delete
// search each slot until a match or the last slot, then apply the action and
// register the done transaction. A tick visits the used slots in order and, on
// each expired slot, emits any timeout or removal event before moving on.
// One request is in service at a time; the next is accepted once the done
// transaction is registered.
// Reset empties the table at once; no clearing pass is needed.
// When the receiver stalls, the single output register holds its transaction
// and the controller waits before issuing the next one.
`timescale 1ns / 1ps
module software_timer_table_core (
	input logic clk,
	input logic arst_n,
	stt_stream_if.sink req_ch,
	stt_stream_if.source rsp_ch
);
	stt_pkg::cmd_t cmd;
	stt_pkg::sts_t sts;
	stt_pkg::req_t req_q;
	stt_pkg::slot_t slot;

	stt_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .req(req_ch.payload), .cmd(cmd), .sts(sts),
		.req_q_o(req_q), .slot_o(slot)
	);

	stt_controller u_ctl (
		.clk(clk), .arst_n(arst_n), .in_valid(req_ch.valid), .in_ready(req_ch.ready),
		.out_valid(rsp_ch.valid), .out_ready(rsp_ch.ready), .rsp(rsp_ch.payload),
		.req_q(req_q), .slot(slot), .sts(sts), .cmd(cmd)
	);
endmodule

// ===== rtl/stt_checker.sv =====
// Port-level checker of the timer table and its bind to the top level.
// Depends on the macros header and stt_pkg.
`timescale 1ns / 1ps
`include "software_timer_table_core_macros.svh"
module stt_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input stt_pkg::rsp_t rsp
);
	`STT_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(rsp), "stalled result changed")
	`STT_ASSERT(a_done_last, clk, arst_n, out_valid |-> (rsp.last == (rsp.event_kind == stt_pkg::EV_DONE)), "last flag not on done")
	`STT_ASSERT(a_event_ok, clk, arst_n, out_valid && !rsp.last |-> !rsp.status, "event with failed status")
	`STT_ASSERT(a_busy, clk, arst_n, in_valid && in_ready |=> !in_ready, "accepted while busy")
endmodule

bind software_timer_table_core stt_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(req_ch.valid), .in_ready(req_ch.ready),
	.out_valid(rsp_ch.valid), .out_ready(rsp_ch.ready), .rsp(rsp_ch.payload)
);

// ===== tb/software_timer_table_core_tb.sv =====
// Testbench of software_timer_table_core: directed and random actions on the timer table,
// with every result checked against a predictor of the table held in the testbench.
// Depends on stt_pkg, stt_stream_if and the core.
`timescale 1ns / 1ps
module software_timer_table_core_tb;
	localparam logic [2:0] ACT_BAD_A = 3'd6;
	localparam logic [2:0] ACT_BAD_B = 3'd7;
	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned RANDOM_ITEMS = 340;
	localparam int unsigned SLOTS = stt_pkg::TimerSlots;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	stt_stream_if #(.T(stt_pkg::req_t)) req_if ();
	stt_stream_if #(.T(stt_pkg::rsp_t)) rsp_if ();

	software_timer_table_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_ch(req_if),
		.rsp_ch(rsp_if)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	stt_pkg::slot_t timers[SLOTS];
	stt_pkg::rsp_t pending_events[$];
	int unsigned mismatches = 0;
	int unsigned items_sent = 0;
	int unsigned timeouts_seen = 0;
	int unsigned removals_seen = 0;
	int unsigned quiet_cycles = 0;
	bit steady = 1'b0;
	logic [31:0] clock_ms = 0;
	logic [7:0] token_pool[20];

	function automatic int find_timer(logic [7:0] tok);
		for (int i = 0; i < SLOTS; i++) begin
			if (timers[i].used && timers[i].token == tok) begin
				return i;
			end
		end
		return -1;
	endfunction

	function automatic void drop_timer(int idx);
		for (int i = idx; i + 1 < SLOTS; i++) begin
			timers[i] = timers[i + 1];
		end
		timers[SLOTS - 1].used = 1'b0;
	endfunction

	function automatic void push_event(stt_pkg::event_kind_t kind, logic [7:0] tok,
			logic [31:0] data, logic st, logic fin);
		stt_pkg::rsp_t r;
		r.event_kind = kind;
		r.event_token = tok;
		r.event_data = data;
		r.status = st;
		r.last = fin;
		pending_events.push_back(r);
	endfunction

	function automatic void predict_events(stt_pkg::req_t q);
		int idx;
		int i;
		logic st;
		logic [31:0] get_data;
		st = 1'b1;
		get_data = '0;
		case (q.action)
			stt_pkg::ACT_ADD: begin
				if (find_timer(q.token) >= 0) begin
					st = 1'b0;
				end else if (!timers[SLOTS - 1].used) begin
					for (i = SLOTS - 1; i > 0; i--) begin
						timers[i] = timers[i - 1];
					end
					timers[0] = '0;
					timers[0].used = 1'b1;
					timers[0].token = q.token;
					timers[0].remaining = q.run_count;
					timers[0].data = q.user_data;
					timers[0].flags = {q.has_delete_handler, q.has_timeout_handler};
					st = 1'b0;
				end
			end
			stt_pkg::ACT_GET: begin
				idx = find_timer(q.token);
				if (idx >= 0) begin
					get_data = timers[idx].data;
					st = 1'b0;
				end
			end
			stt_pkg::ACT_START: begin
				idx = find_timer(q.token);
				if (idx >= 0) begin
					timers[idx].running = 1'b1;
					timers[idx].start_time = q.current_time;
					timers[idx].period = q.interval_ms;
					st = 1'b0;
				end
			end
			stt_pkg::ACT_STOP: begin
				idx = find_timer(q.token);
				if (idx >= 0) begin
					timers[idx].running = 1'b0;
					st = 1'b0;
				end
			end
			stt_pkg::ACT_DELETE: begin
				idx = find_timer(q.token);
				if (idx >= 0) begin
					if (timers[idx].flags[1]) begin
						push_event(stt_pkg::EV_REMOVED, timers[idx].token, timers[idx].data,
							1'b0, 1'b0);
					end
					drop_timer(idx);
					st = 1'b0;
				end
			end
			stt_pkg::ACT_TICK: begin
				i = 0;
				while (i < SLOTS && timers[i].used) begin
					if (32'hFFFF_FFFF - q.current_time < timers[i].period) begin
						timers[i].start_time = '0;
						i++;
						continue;
					end
					if (timers[i].running &&
							q.current_time >= 32'(timers[i].start_time + timers[i].period)) begin
						if (timers[i].flags[0]) begin
							push_event(stt_pkg::EV_TIMEOUT, timers[i].token, timers[i].data,
								1'b0, 1'b0);
						end
						timers[i].start_time = q.current_time;
						if (timers[i].remaining > 0) begin
							timers[i].remaining--;
							if (timers[i].remaining == 0) begin
								if (timers[i].flags[1]) begin
									push_event(stt_pkg::EV_REMOVED, timers[i].token,
										timers[i].data, 1'b0, 1'b0);
								end
								drop_timer(i);
								continue;
							end
						end
					end
					i++;
				end
				st = 1'b0;
			end
			default: begin
			end
		endcase
		push_event(stt_pkg::EV_DONE, q.token, get_data, st, 1'b1);
	endfunction

	function automatic stt_pkg::req_t make_req(logic [2:0] act, logic [7:0] tok,
			logic [7:0] cnt, logic [31:0] ival, logic [31:0] now, logic [31:0] ud,
			logic th, logic dh);
		stt_pkg::req_t q;
		q.action = act;
		q.token = tok;
		q.run_count = cnt;
		q.interval_ms = ival;
		q.current_time = now;
		q.user_data = ud;
		q.has_timeout_handler = th;
		q.has_delete_handler = dh;
		return q;
	endfunction

	task automatic send_req(stt_pkg::req_t q);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.payload <= q;
		do begin
			@(posedge clk);
		end while (!req_if.ready);
		predict_events(q);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		req_if.valid <= 1'b0;
		while (pending_events.size() != 0) begin
			@(negedge clk);
		end
	endtask

	always begin
		int stall;
		rsp_if.ready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_if.ready <= 1'b1;
			do begin
				@(posedge clk);
			end while (!rsp_if.valid);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		stt_pkg::rsp_t exp_r;
		stt_pkg::rsp_t got;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got = rsp_if.payload;
			if (pending_events.size() == 0) begin
				$error("unexpected transaction: kind %0d token %0d", got.event_kind,
					got.event_token);
				mismatches++;
			end else begin
				exp_r = pending_events.pop_front();
				if (got.event_kind == stt_pkg::EV_TIMEOUT) timeouts_seen++;
				if (got.event_kind == stt_pkg::EV_REMOVED) removals_seen++;
				if (got.event_kind !== exp_r.event_kind) begin
					$error("event_kind expected %0d actual %0d", exp_r.event_kind, got.event_kind);
					mismatches++;
				end
				if (got.event_token !== exp_r.event_token) begin
					$error("event_token expected %0d actual %0d", exp_r.event_token,
						got.event_token);
					mismatches++;
				end
				if (got.event_data !== exp_r.event_data) begin
					$error("event_data expected %h actual %h", exp_r.event_data, got.event_data);
					mismatches++;
				end
				if (got.status !== exp_r.status) begin
					$error("status expected %0d actual %0d", exp_r.status, got.status);
					mismatches++;
				end
				if (got.last !== exp_r.last) begin
					$error("last expected %0d actual %0d", exp_r.last, got.last);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == STALL_LIMIT) begin
				$display("** software_timer_table_core: FAILED **");
				$finish;
			end
		end
	end

	task automatic test_directed();
		send_req(make_req(stt_pkg::ACT_GET, 8'h00, 0, 0, 0, 0, 0, 0));
		send_req(make_req(stt_pkg::ACT_START, 8'hFF, 0, 5, 0, 0, 0, 0));
		send_req(make_req(stt_pkg::ACT_STOP, 8'h11, 0, 0, 0, 0, 0, 0));
		send_req(make_req(stt_pkg::ACT_DELETE, 8'h22, 0, 0, 0, 0, 0, 0));
		send_req(make_req(stt_pkg::ACT_ADD, 8'hFF, 8'd2, 0, 0, 32'hFFFF_FFFF, 1, 1));
		send_req(make_req(stt_pkg::ACT_ADD, 8'hFF, 8'd9, 0, 0, 32'h1234_5678, 0, 0));
		send_req(make_req(stt_pkg::ACT_ADD, 8'h00, 8'd0, 0, 0, 32'hA5A5_5A5A, 1, 0));
		send_req(make_req(stt_pkg::ACT_ADD, 8'h80, 8'hFF, 0, 0, 32'h0, 0, 1));
		send_req(make_req(stt_pkg::ACT_GET, 8'hFF, 0, 0, 0, 0, 0, 0));
		send_req(make_req(stt_pkg::ACT_START, 8'hFF, 0, 10, 100, 0, 0, 0));
		send_req(make_req(stt_pkg::ACT_START, 8'h00, 0, 0, 100, 0, 0, 0));
		send_req(make_req(stt_pkg::ACT_START, 8'h80, 0, 3, 100, 0, 0, 0));
		send_req(make_req(stt_pkg::ACT_TICK, 8'h5A, 0, 0, 105, 0, 0, 0));
		send_req(make_req(stt_pkg::ACT_TICK, 8'h00, 0, 0, 110, 0, 0, 0));
		send_req(make_req(stt_pkg::ACT_STOP, 8'h00, 0, 0, 0, 0, 0, 0));
		send_req(make_req(stt_pkg::ACT_TICK, 8'h01, 0, 0, 120, 0, 0, 0));
		send_req(make_req(stt_pkg::ACT_DELETE, 8'h80, 0, 0, 0, 0, 0, 0));
		send_req(make_req(stt_pkg::ACT_DELETE, 8'h00, 0, 0, 0, 0, 0, 0));
		send_req(make_req(ACT_BAD_A, 8'h33, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			1, 1));
		send_req(make_req(ACT_BAD_B, 8'h44, 0, 0, 0, 0, 0, 0));
		wait_drained();
	endtask

	task automatic test_full_table();
		for (int i = 0; i < SLOTS + 2; i++) begin
			send_req(make_req(stt_pkg::ACT_ADD, 8'(8'h40 + i), 8'(i % 3), 0, 0, $urandom(),
				i[0], i[1]));
		end
		for (int i = 0; i < SLOTS; i += 2) begin
			send_req(make_req(stt_pkg::ACT_START, 8'(8'h40 + i), 0, 1, clock_ms, 0, 0, 0));
		end
		clock_ms = clock_ms + 2;
		send_req(make_req(stt_pkg::ACT_TICK, 8'h00, 0, 0, clock_ms, 0, 0, 0));
		clock_ms = clock_ms + 2;
		send_req(make_req(stt_pkg::ACT_TICK, 8'h00, 0, 0, clock_ms, 0, 0, 0));
		for (int i = 0; i < SLOTS + 2; i++) begin
			send_req(make_req(stt_pkg::ACT_DELETE, 8'(8'h40 + i), 0, 0, 0, 0, 0, 0));
		end
		wait_drained();
	endtask

	task automatic test_time_wrap();
		send_req(make_req(stt_pkg::ACT_ADD, 8'h77, 0, 0, 0, 32'hCAFE_F00D, 1, 1));
		send_req(make_req(stt_pkg::ACT_ADD, 8'h78, 1, 0, 0, 32'h0BAD_BEEF, 1, 1));
		send_req(make_req(stt_pkg::ACT_START, 8'h77, 0, 32'h200, 32'hFFFF_FE00, 0, 0, 0));
		send_req(make_req(stt_pkg::ACT_START, 8'h78, 0, 32'hFFFF_FFFF, 32'h0, 0, 0, 0));
		send_req(make_req(stt_pkg::ACT_TICK, 8'h00, 0, 0, 32'hFFFF_FFF0, 0, 0, 0));
		send_req(make_req(stt_pkg::ACT_TICK, 8'h00, 0, 0, 32'h0000_0000, 0, 0, 0));
		send_req(make_req(stt_pkg::ACT_STOP, 8'h77, 0, 0, 0, 0, 0, 0));
		send_req(make_req(stt_pkg::ACT_TICK, 8'h00, 0, 0, 32'hFFFF_FFFF, 0, 0, 0));
		send_req(make_req(stt_pkg::ACT_START, 8'h77, 0, 32'h0, 32'h10, 0, 0, 0));
		send_req(make_req(stt_pkg::ACT_TICK, 8'h00, 0, 0, 32'h10, 0, 0, 0));
		send_req(make_req(stt_pkg::ACT_DELETE, 8'h77, 0, 0, 0, 0, 0, 0));
		send_req(make_req(stt_pkg::ACT_DELETE, 8'h78, 0, 0, 0, 0, 0, 0));
		wait_drained();
	endtask

	task automatic test_random();
		stt_pkg::req_t q;
		int pick;
		logic [7:0] tok;
		for (int i = 0; i < 20; i++) begin
			token_pool[i] = 8'($urandom_range(0, 255));
		end
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0) steady = ~steady;
			if (n == RANDOM_ITEMS / 2) wait_drained();
			tok = token_pool[$urandom_range(0, 19)];
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				q = make_req(stt_pkg::ACT_ADD, tok, 8'($urandom_range(0, 4)), 0, 0, $urandom(),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end else if (pick < 35) begin
				q = make_req(stt_pkg::ACT_START, tok, 0, $urandom_range(0, 25), clock_ms,
					0, 0, 0);
			end else if (pick < 65) begin
				clock_ms = clock_ms + $urandom_range(0, 12);
				q = make_req(stt_pkg::ACT_TICK, tok, 0, 0, clock_ms, 0, 0, 0);
			end else if (pick < 72) begin
				q = make_req(stt_pkg::ACT_GET, tok, 0, 0, 0, 0, 0, 0);
			end else if (pick < 78) begin
				q = make_req(stt_pkg::ACT_STOP, tok, 0, 0, 0, 0, 0, 0);
			end else if (pick < 84) begin
				q = make_req(stt_pkg::ACT_DELETE, tok, 0, 0, 0, 0, 0, 0);
			end else begin
				q = make_req(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), $urandom(), $urandom(), $urandom(),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end
			send_req(q);
		end
		steady = 1'b0;
		wait_drained();
	endtask

	initial begin
		req_if.valid = 1'b0;
		req_if.payload = '0;
		for (int i = 0; i < SLOTS; i++) begin
			timers[i] = '0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_full_table();
		test_time_wrap();
		test_random();
		repeat (80) @(posedge clk);
		$display("Sent %0d transactions; saw %0d timeout and %0d removal events.",
			items_sent, timeouts_seen, removals_seen);
		if (mismatches == 0) begin
			$display("** software_timer_table_core: PASSED **");
		end else begin
			$display("** software_timer_table_core: FAILED **");
		end
		$finish;
	end
endmodule
